/* rtl/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: command and
// character codes, field widths and the transfer payload structs.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int DEF_COLUMNS  = 80;
  localparam int DEF_ROWS     = 25;
  localparam int DEF_TAB_STOP = 4;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int POS_W  = 12;
  localparam int CELL_W = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index taken from the word address bit of paddr.
  localparam logic REG_TEXT_COLOR = 1'b0;

  localparam logic [2:0] CMD_PUT_CHAR   = 3'd0;
  localparam logic [2:0] CMD_SET_CURSOR = 3'd1;
  localparam logic [2:0] CMD_WRITE_AT   = 3'd2;
  localparam logic [2:0] CMD_CLEAR      = 3'd3;
  localparam logic [2:0] CMD_READ_CELL  = 3'd4;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [7:0] RESET_COLOR = 8'h0F;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] char_code;
    logic [7:0] cell_color;
    logic [7:0] col_x;
    logic [7:0] row_y;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col_out;
    logic [ROW_W-1:0]  cursor_row_out;
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_data;
  } out_item_t;

endpackage

/* rtl/tcw_screen_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
  parameter int DEPTH  = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [tcw_pkg::CELL_W-1:0]  wdata,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [tcw_pkg::CELL_W-1:0]  rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
  logic [tcw_pkg::CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/tcw_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cfg_regs
// APB-style register port holding the text color attribute.
// ----------------------------------------------------------------------------
module tcw_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcw_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tcw_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [7:0]                      text_color
);

  logic [7:0] text_color_r;
  logic [7:0] text_color_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    text_color_nxt = text_color_r;
    if (wr_en && (paddr[2] == tcw_pkg::REG_TEXT_COLOR)) begin
      text_color_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= tcw_pkg::RESET_COLOR;
    end else begin
      text_color_r <= text_color_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == tcw_pkg::REG_TEXT_COLOR) begin
      prdata = tcw_pkg::CFG_DATA_W'(text_color_r);
    end
  end

  assign text_color = text_color_r;

endmodule

/* rtl/text_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine over a single-port-write screen cell memory.
// ----------------------------------------------------------------------------
// Commands are taken one at a time. Put char, set cursor, write at position,
// the unused codes and a read cell off the screen load their result straight
// from the idle state, so such transfers can follow each other every cycle
// while results are not stalled; a read cell on the screen passes through the
// read state, which takes the registered memory data, and the response state,
// which loads the result. A put char that runs past the last row scrolls the
// screen: it copies each row up one, then blanks the bottom row and loads the
// result; clear fills every cell with blanks and then loads the result. The
// memory takes one write per cycle. A stalled result holds off the next
// command. After reset the block fills the screen with blanks before it takes
// its first command; register writes are taken throughout.
module text_console_writer #(
  parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS     = tcw_pkg::DEF_ROWS,
  parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tcw_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tcw_pkg::out_item_t              out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcw_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tcw_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int COPY_N = CELLS - COLUMNS;

  typedef logic [127:0][7:0] tab_tbl_t;

  function automatic tab_tbl_t build_tab();
    tab_tbl_t t;
    for (int i = 0; i < 128; i++) begin
      t[i] = 8'((i / TAB_STOP + 1) * TAB_STOP);
    end
    return t;
  endfunction

  localparam tab_tbl_t TAB_NEXT = build_tab();

  function automatic logic [ADDR_W-1:0] lin(input logic [tcw_pkg::ROW_W-1:0] r,
                                            input logic [tcw_pkg::COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  typedef enum logic [2:0] {ST_FILL, ST_IDLE, ST_SCROLL, ST_READ, ST_RESP} state_t;

  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [7:0]                   fill_color_r, fill_color_nxt;
  logic                         fill_init_r, fill_init_nxt;
  logic [tcw_pkg::COL_W-1:0]    cur_col_r, cur_col_nxt;
  logic [tcw_pkg::ROW_W-1:0]    cur_row_r, cur_row_nxt;
  logic [tcw_pkg::CELL_W-1:0]   cell_r, cell_nxt;
  logic                         out_valid_r, out_valid_nxt;
  tcw_pkg::out_item_t           out_data_r, out_data_nxt;

  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;
  logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]            mem_raddr;
  logic [tcw_pkg::CELL_W-1:0]   mem_rdata;

  logic [7:0]                   text_color;
  logic [ADDR_W-1:0]            cur_pos;
  logic [ADDR_W-1:0]            in_pos;
  logic                         in_x_ok;
  logic                         in_y_ok;
  logic                         out_free;
  logic                         accept;
  logic [7:0]                   tab_col;

  tcw_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .text_color (text_color)
  );

  tcw_screen_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign cur_pos  = lin(cur_row_r, cur_col_r);
  assign in_pos   = lin(in_data.row_y[tcw_pkg::ROW_W-1:0],
                        in_data.col_x[tcw_pkg::COL_W-1:0]);
  assign in_x_ok  = in_data.col_x < 8'(COLUMNS);
  assign in_y_ok  = in_data.row_y < 8'(ROWS);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign tab_col  = TAB_NEXT[cur_col_r];

  always_comb begin
    logic do_nl;
    logic defer;
    logic load;

    do_nl          = 1'b0;
    defer          = 1'b0;
    load           = 1'b0;
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    fill_color_nxt = fill_color_r;
    fill_init_nxt  = fill_init_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    cell_nxt       = cell_r;
    mem_we         = 1'b0;
    mem_waddr      = cur_pos;
    mem_wdata      = {text_color, tcw_pkg::CH_SPACE};
    mem_raddr      = in_pos;

    case (state_r)
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[ADDR_W-1:0];
        mem_wdata = {fill_color_r, tcw_pkg::CH_SPACE};
        if (cnt_r == CNT_W'(CELLS - 1)) begin
          state_nxt = fill_init_r ? ST_IDLE : ST_RESP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          cell_nxt = '0;
          case (in_data.command)
            tcw_pkg::CMD_PUT_CHAR: begin
              case (in_data.char_code)
                tcw_pkg::CH_NEWLINE: begin
                  do_nl = 1'b1;
                end
                tcw_pkg::CH_RETURN: begin
                  cur_col_nxt = '0;
                end
                tcw_pkg::CH_TAB: begin
                  if (tab_col >= 8'(COLUMNS)) begin
                    do_nl = 1'b1;
                  end else begin
                    cur_col_nxt = tab_col[tcw_pkg::COL_W-1:0];
                  end
                end
                tcw_pkg::CH_BACKSPACE: begin
                  // Steps back over a line start; nothing happens at the top left.
                  if (cur_pos != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_pos - 1'b1;
                    if (cur_col_r != '0) begin
                      cur_col_nxt = cur_col_r - 1'b1;
                    end else begin
                      cur_row_nxt = cur_row_r - 1'b1;
                      cur_col_nxt = tcw_pkg::COL_W'(COLUMNS - 1);
                    end
                  end
                end
                default: begin
                  mem_we    = 1'b1;
                  mem_wdata = {text_color, in_data.char_code};
                  if (cur_col_r == tcw_pkg::COL_W'(COLUMNS - 1)) begin
                    do_nl = 1'b1;
                  end else begin
                    cur_col_nxt = cur_col_r + 1'b1;
                  end
                end
              endcase
            end
            tcw_pkg::CMD_SET_CURSOR: begin
              if (in_x_ok) begin
                cur_col_nxt = in_data.col_x[tcw_pkg::COL_W-1:0];
              end
              if (in_y_ok) begin
                cur_row_nxt = in_data.row_y[tcw_pkg::ROW_W-1:0];
              end
            end
            tcw_pkg::CMD_WRITE_AT: begin
              if (in_x_ok && in_y_ok) begin
                mem_we    = 1'b1;
                mem_waddr = in_pos;
                mem_wdata = {in_data.cell_color, in_data.char_code};
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              defer          = 1'b1;
              state_nxt      = ST_FILL;
              cnt_nxt        = '0;
              fill_color_nxt = text_color;
              fill_init_nxt  = 1'b0;
              cur_col_nxt    = '0;
              cur_row_nxt    = '0;
            end
            tcw_pkg::CMD_READ_CELL: begin
              if (in_x_ok && in_y_ok) begin
                defer     = 1'b1;
                state_nxt = ST_READ;
              end
            end
            default: begin
            end
          endcase

          if (do_nl) begin
            cur_col_nxt = '0;
            if (cur_row_r == tcw_pkg::ROW_W'(ROWS - 1)) begin
              defer     = 1'b1;
              state_nxt = ST_SCROLL;
              cnt_nxt   = '0;
            end else begin
              cur_row_nxt = cur_row_r + 1'b1;
            end
          end

          load = !defer;
        end
      end

      ST_SCROLL: begin
        // Read one row ahead and write the returned cell one step behind.
        mem_raddr = ADDR_W'(cnt_r + CNT_W'(COLUMNS));
        mem_we    = (cnt_r != '0);
        mem_waddr = ADDR_W'(cnt_r - 1'b1);
        mem_wdata = mem_rdata;
        if (cnt_r == CNT_W'(COPY_N)) begin
          state_nxt      = ST_FILL;
          fill_color_nxt = text_color;
          fill_init_nxt  = 1'b0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_READ: begin
        cell_nxt  = mem_rdata;
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.cursor_col_out  = cur_col_nxt;
      out_data_nxt.cursor_row_out  = cur_row_nxt;
      out_data_nxt.cursor_position = tcw_pkg::POS_W'(lin(cur_row_nxt, cur_col_nxt));
      out_data_nxt.cell_data       = cell_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r     <= cell_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r      <= ST_FILL;
      cnt_r        <= '0;
      fill_color_r <= tcw_pkg::RESET_COLOR;
      fill_init_r  <= 1'b1;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      fill_color_r <= fill_color_nxt;
      fill_init_r  <= fill_init_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console writer. A short directed list
// covers control characters, cursor limits, scrolling, clear and reads out
// of range; a long random run follows under several text colors. Each
// result is compared with a cycle-free model of the screen and cursor kept
// in the bench, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int COLS        = tcw_pkg::DEF_COLUMNS;
  localparam int ROWS        = tcw_pkg::DEF_ROWS;
  localparam int TAB         = tcw_pkg::DEF_TAB_STOP;
  localparam int CELLS       = COLS * ROWS;
  localparam int MAX_WAIT    = 6;
  localparam int SETTLE      = 8;
  localparam int NUM_PHASES  = 5;
  localparam int PHASE_ITEMS = 200;
  // Longest correct silence is a scroll or clear walking the whole screen.
  localparam int STALL_LIMIT = 10 * CELLS + 1000;

  localparam logic [2:0] CMD_UNUSED_LAST = 3'd7;
  localparam logic [tcw_pkg::CFG_ADDR_W-1:0] ADDR_TEXT_COLOR = 3'd0;
  localparam logic [tcw_pkg::CFG_ADDR_W-1:0] ADDR_UNMAPPED   = 3'd4;

  typedef struct {
    tcw_pkg::in_item_t  item;
    bit                 typed;
    tcw_pkg::out_item_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  tcw_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  tcw_pkg::out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [tcw_pkg::CFG_ADDR_W-1:0] paddr;
  logic [tcw_pkg::CFG_DATA_W-1:0] pwdata;
  logic [tcw_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  // Bench copy of the console state.
  logic [15:0] screen [CELLS];
  int          cur_col;
  int          cur_row;
  logic [7:0]  text_color;

  tcw_pkg::out_item_t cursor_reports [$];
  int        failures = 0;
  int        idle_cycles = 0;
  int        stall_left = 0;
  bit        calm_run = 1'b0;

  text_console_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int draw_wait();
    return calm_run ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  function automatic void blank_screen(logic [7:0] color);
    for (int i = 0; i < CELLS; i++) screen[i] = {color, tcw_pkg::CH_SPACE};
  endfunction

  function automatic void store_glyph(int x, int y, logic [15:0] glyph);
    if (x < COLS && y < ROWS) screen[y * COLS + x] = glyph;
  endfunction

  // Moving past the last row shifts every row up and blanks the bottom one.
  function automatic void next_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
      for (int x = 0; x < COLS; x++)
        screen[(ROWS - 1) * COLS + x] = {text_color, tcw_pkg::CH_SPACE};
      cur_row = ROWS - 1;
    end
  endfunction

  function automatic void put_char(logic [7:0] ch);
    if (ch == tcw_pkg::CH_NEWLINE) begin
      next_line();
    end else if (ch == tcw_pkg::CH_RETURN) begin
      cur_col = 0;
    end else if (ch == tcw_pkg::CH_TAB) begin
      cur_col = (cur_col / TAB + 1) * TAB;
      if (cur_col >= COLS) next_line();
    end else if (ch == tcw_pkg::CH_BACKSPACE) begin
      if (cur_col > 0) begin
        cur_col--;
        store_glyph(cur_col, cur_row, {text_color, tcw_pkg::CH_SPACE});
      end else if (cur_row > 0) begin
        cur_row--;
        cur_col = COLS - 1;
        store_glyph(cur_col, cur_row, {text_color, tcw_pkg::CH_SPACE});
      end
    end else begin
      store_glyph(cur_col, cur_row, {text_color, ch});
      cur_col++;
      if (cur_col >= COLS) next_line();
    end
  endfunction

  function automatic tcw_pkg::out_item_t apply_command(tcw_pkg::in_item_t it);
    tcw_pkg::out_item_t res;
    logic [15:0]        data;
    int                 x;
    int                 y;
    data = '0;
    x = int'(it.col_x);
    y = int'(it.row_y);
    case (it.command)
      tcw_pkg::CMD_PUT_CHAR: put_char(it.char_code);
      tcw_pkg::CMD_SET_CURSOR: begin
        if (x < COLS) cur_col = x;
        if (y < ROWS) cur_row = y;
      end
      tcw_pkg::CMD_WRITE_AT: store_glyph(x, y, {it.cell_color, it.char_code});
      tcw_pkg::CMD_CLEAR: begin
        blank_screen(text_color);
        cur_col = 0;
        cur_row = 0;
      end
      tcw_pkg::CMD_READ_CELL: begin
        if (x < COLS && y < ROWS) data = screen[y * COLS + x];
      end
      default: ;
    endcase
    res.cursor_col_out  = tcw_pkg::COL_W'(cur_col);
    res.cursor_row_out  = tcw_pkg::ROW_W'(cur_row);
    res.cursor_position = tcw_pkg::POS_W'(cur_row * COLS + cur_col);
    res.cell_data       = data;
    return res;
  endfunction

  function automatic tcw_pkg::in_item_t mk(logic [2:0] cmd, int ch, int color,
                                           int x, int y);
    tcw_pkg::in_item_t it;
    it.command    = cmd;
    it.char_code  = 8'(ch);
    it.cell_color = 8'(color);
    it.col_x      = 8'(x);
    it.row_y      = 8'(y);
    return it;
  endfunction

  function automatic tcw_pkg::out_item_t rep(int col, int row, int data);
    tcw_pkg::out_item_t r;
    r.cursor_col_out  = tcw_pkg::COL_W'(col);
    r.cursor_row_out  = tcw_pkg::ROW_W'(row);
    r.cursor_position = tcw_pkg::POS_W'(row * COLS + col);
    r.cell_data       = 16'(data);
    return r;
  endfunction

  // Mostly in-range positions and plain text, with control characters and
  // wild coordinates mixed in; clears are rare since each one walks the screen.
  function automatic tcw_pkg::in_item_t random_command();
    tcw_pkg::in_item_t it;
    int                pick;
    int                sel;
    it.char_code  = 8'($urandom);
    it.cell_color = 8'($urandom);
    it.col_x      = 8'($urandom);
    it.row_y      = 8'($urandom);
    if ($urandom_range(0, 4) != 0) begin
      it.col_x = 8'($urandom_range(0, COLS - 1));
      it.row_y = ($urandom_range(0, 3) == 0) ? 8'(ROWS - 1)
                                              : 8'($urandom_range(0, ROWS - 1));
    end
    pick = int'($urandom_range(0, 99));
    if (pick < 50) begin
      it.command = tcw_pkg::CMD_PUT_CHAR;
      sel = int'($urandom_range(0, 19));
      case (sel)
        0: it.char_code = tcw_pkg::CH_NEWLINE;
        1: it.char_code = tcw_pkg::CH_RETURN;
        2: it.char_code = tcw_pkg::CH_TAB;
        3: it.char_code = tcw_pkg::CH_BACKSPACE;
        default: ;
      endcase
    end else if (pick < 62) begin
      it.command = tcw_pkg::CMD_SET_CURSOR;
    end else if (pick < 77) begin
      it.command = tcw_pkg::CMD_WRITE_AT;
    end else if (pick < 95) begin
      it.command = tcw_pkg::CMD_READ_CELL;
    end else if (pick < 97) begin
      it.command = tcw_pkg::CMD_CLEAR;
    end else begin
      it.command = 3'($urandom_range(int'(tcw_pkg::CMD_READ_CELL) + 1,
                                     int'(CMD_UNUSED_LAST)));
    end
    return it;
  endfunction

  task automatic transfer_command(tcw_pkg::in_item_t it, tcw_pkg::out_item_t want);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cursor_reports.push_back(want);
  endtask

  task automatic apb_access(bit wr, logic [tcw_pkg::CFG_ADDR_W-1:0] addr,
                            logic [tcw_pkg::CFG_DATA_W-1:0] wdata,
                            output logic [tcw_pkg::CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (cursor_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic report_mismatch(string field, int want, int got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    failures++;
  endtask

  // Result side: check every accepted transfer and draw the next stall.
  always @(posedge clk) begin
    tcw_pkg::out_item_t want;
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cursor_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          failures++;
        end else begin
          want = cursor_reports.pop_front();
          if (out_data.cursor_col_out !== want.cursor_col_out)
            report_mismatch("cursor_col_out", want.cursor_col_out, out_data.cursor_col_out);
          if (out_data.cursor_row_out !== want.cursor_row_out)
            report_mismatch("cursor_row_out", want.cursor_row_out, out_data.cursor_row_out);
          if (out_data.cursor_position !== want.cursor_position)
            report_mismatch("cursor_position", want.cursor_position,
                            out_data.cursor_position);
          if (out_data.cell_data !== want.cell_data)
            report_mismatch("cell_data", want.cell_data, out_data.cell_data);
        end
        stall_left = draw_wait();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t                      directed [$];
    stim_row_t                      r;
    logic [tcw_pkg::CFG_DATA_W-1:0] rdata;
    logic [7:0]                     color;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;

    text_color = tcw_pkg::RESET_COLOR;
    blank_screen(tcw_pkg::RESET_COLOR);
    cur_col = 0;
    cur_row = 0;

    // Rows with typed results hold values that follow from the screen state at a
    // glance; the rest rely on the bench model.
    directed.push_back('{mk(tcw_pkg::CMD_READ_CELL, 0, 0, 0, 0), 1,
                         rep(0, 0, {tcw_pkg::RESET_COLOR, tcw_pkg::CH_SPACE})});
    directed.push_back('{mk(tcw_pkg::CMD_READ_CELL, 0, 0, 'hFF, 'hFF), 1, rep(0, 0, 0)});
    directed.push_back('{mk(tcw_pkg::CMD_PUT_CHAR, 'h41, 0, 0, 0), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_PUT_CHAR, 'hFF, 'hFF, 'hFF, 'hFF), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_PUT_CHAR, 'h00, 0, 0, 0), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_TAB, 0, 0, 0), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_BACKSPACE, 0, 0, 0), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_RETURN, 0, 0, 0), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_NEWLINE, 0, 0, 0), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_BACKSPACE, 0, 0, 0), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_SET_CURSOR, 0, 0, 0, 0), 1, rep(0, 0, 0)});
    directed.push_back('{mk(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_BACKSPACE, 0, 0, 0), 1,
                         rep(0, 0, 0)});
    directed.push_back('{mk(tcw_pkg::CMD_SET_CURSOR, 0, 0, COLS - 1, ROWS - 1), 1,
                         rep(COLS - 1, ROWS - 1, 0)});
    directed.push_back('{mk(tcw_pkg::CMD_PUT_CHAR, 'h7E, 0, 0, 0), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_READ_CELL, 0, 0, COLS - 1, ROWS - 2), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_SET_CURSOR, 0, 0, 'hFF, 3), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_SET_CURSOR, 0, 0, COLS - 2, 'hC8), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_TAB, 0, 0, 0), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_WRITE_AT, 'h00, 'hFF, COLS - 1, ROWS - 1), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_WRITE_AT, 'hFF, 'h00, COLS, 0), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_READ_CELL, 0, 0, COLS - 1, ROWS - 1), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_SET_CURSOR, 0, 0, 0, ROWS - 1), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CH_NEWLINE, 0, 0, 0), 0, '0});
    directed.push_back('{mk(tcw_pkg::CMD_CLEAR, 0, 0, 0, 0), 1, rep(0, 0, 0)});
    directed.push_back('{mk(tcw_pkg::CMD_READ_CELL, 0, 0, COLS - 1, ROWS - 1), 1,
                         rep(0, 0, {tcw_pkg::RESET_COLOR, tcw_pkg::CH_SPACE})});
    directed.push_back('{mk(CMD_UNUSED_LAST, 'hFF, 'hFF, 'hFF, 'hFF), 1, rep(0, 0, 0)});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      r = directed[i];
      r.want = r.typed ? r.want : apply_command(r.item);
      if (r.typed) void'(apply_command(r.item));
      transfer_command(r.item, r.want);
    end
    in_valid <= 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: color = 8'h00;
        1: color = 8'hFF;
        default: color = 8'($urandom);
      endcase
      apb_access(1'b1, ADDR_TEXT_COLOR, {24'h0, color}, rdata);
      text_color = color;
      if (phase == 2) begin
        // A write past the register list must leave the color untouched.
        apb_access(1'b1, ADDR_UNMAPPED, $urandom, rdata);
        apb_access(1'b0, ADDR_TEXT_COLOR, '0, rdata);
        if (rdata[7:0] !== text_color) begin
          $display("%0t: text_color readback mismatch, expected %0h, actual %0h",
                   $time, text_color, rdata[7:0]);
          failures++;
        end
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        tcw_pkg::in_item_t it;
        if (n % 40 == 0) calm_run = ($urandom_range(0, 3) == 0);
        it = random_command();
        transfer_command(it, apply_command(it));
      end
      in_valid <= 1'b0;
      calm_run = 1'b0;
    end

    wait_drained();
    if (failures == 0 && cursor_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
